@@ rtl/core/bft_pkg.sv @@
// shared constants and types for the breadth-first traversal engine
`default_nettype none
package bft_pkg;
  localparam int MAX_VERTICES = 256;
  localparam int MAX_DEGREE   = 32;
  localparam int VERT_W       = 8;
  localparam int DEG_W        = 6;
  localparam int DIDX_W       = $clog2(MAX_DEGREE);
  localparam int PTR_W        = 9;

  typedef logic [VERT_W-1:0] vert_t;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_START = 2'd2,
    MODE_STEP  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    EV_DISC = 2'd0,
    EV_PROC = 2'd1,
    EV_ACC  = 2'd2,
    EV_REJ  = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    COL_WHITE = 2'd0,
    COL_GRAY  = 2'd1,
    COL_BLACK = 2'd2,
    COL_SPARE = 2'd3
  } colour_t;
endpackage
`default_nettype wire

@@ rtl/core/breadth_first_traversal_top.sv @@
// breadth-first traversal engine: adjacency, colour and queue memories with a sequencer
// Commands are taken when start is high and busy is low; results appear one per
// out_valid pulse and cannot be held off. After reset, and after every clear, a pass
// over all vertices zeroes the degree and colour memories while busy stays high;
// a clear ends with one accepted result. A step walks the stored neighbours one
// entry at a time, each through a table read, a colour read, and a mark and enqueue.
`default_nettype none
module breadth_first_traversal_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output      logic              busy,
  input  wire logic [1:0]        in_mode,
  input  wire bft_pkg::vert_t    in_src_vertex,
  input  wire bft_pkg::vert_t    in_dst_vertex,
  output      logic              out_valid,
  output      logic [1:0]        out_event_kind,
  output      bft_pkg::vert_t    out_vertex_id,
  output      logic              out_last_of_run,
  output      logic              out_queue_empty
);
  import bft_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_ADD, S_START, S_QRD, S_DEG, S_NRD, S_CRD, S_CHK, S_DONE
  } state_t;

  state_t              state_r;
  logic                clr_ack_r;
  logic [VERT_W-1:0]   cnt_r;
  vert_t               src_r, dst_r, u_r, w_r;
  logic [DEG_W-1:0]    deg_r, i_r;
  logic [PTR_W-1:0]    head_r, tail_r;
  logic                out_valid_r, out_last_r, out_empty_r;
  logic [1:0]          out_kind_r;
  vert_t               out_vid_r;

  logic [VERT_W-1:0]   tbl_mem [MAX_VERTICES*MAX_DEGREE];
  logic [DEG_W-1:0]    deg_mem [MAX_VERTICES];
  logic [1:0]          col_mem [MAX_VERTICES];
  logic [VERT_W-1:0]   q_mem   [MAX_VERTICES];
  logic [VERT_W-1:0]   tbl_q, q_q;
  logic [DEG_W-1:0]    deg_q;
  logic [1:0]          col_q;

  vert_t               deg_ra, col_ra, deg_wa, col_wa;
  logic                deg_we, col_we, tbl_we, q_we;
  logic [DEG_W-1:0]    deg_wd;
  logic [1:0]          col_wd;

  assign deg_ra = (state_r == S_IDLE) ? in_src_vertex : q_q;
  assign col_ra = (state_r == S_IDLE) ? in_src_vertex : tbl_q;

  always_comb begin
    deg_we = 1'b0; deg_wa = cnt_r; deg_wd = '0;
    col_we = 1'b0; col_wa = cnt_r; col_wd = COL_WHITE;
    tbl_we = 1'b0; q_we = 1'b0;
    unique case (state_r)
      S_CLR: begin
        deg_we = 1'b1; col_we = 1'b1;
      end
      S_ADD: begin
        if (deg_q < DEG_W'(MAX_DEGREE)) begin
          tbl_we = 1'b1; deg_we = 1'b1; deg_wa = src_r; deg_wd = deg_q + 1'b1;
        end
      end
      S_START: begin
        if (col_q == COL_WHITE) begin
          col_we = 1'b1; col_wa = src_r; col_wd = COL_GRAY; q_we = 1'b1;
        end
      end
      S_CHK: begin
        if (col_q == COL_WHITE) begin
          col_we = 1'b1; col_wa = w_r; col_wd = COL_GRAY; q_we = 1'b1;
        end
      end
      S_DONE: begin
        col_we = 1'b1; col_wa = u_r; col_wd = COL_BLACK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[{src_r, deg_q[DIDX_W-1:0]}] <= dst_r;
    tbl_q <= tbl_mem[{u_r, i_r[DIDX_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (deg_we) deg_mem[deg_wa] <= deg_wd;
    deg_q <= deg_mem[deg_ra];
  end

  always_ff @(posedge clk) begin
    if (col_we) col_mem[col_wa] <= col_wd;
    col_q <= col_mem[col_ra];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[tail_r[VERT_W-1:0]] <= (state_r == S_START) ? src_r : w_r;
    q_q <= q_mem[head_r[VERT_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_ack_r <= 1'b0;
      cnt_r     <= '0;
      head_r    <= '0;
      tail_r    <= '0;
      out_valid_r <= 1'b0;
      out_last_r <= 1'b0; out_empty_r <= 1'b1; out_kind_r <= EV_ACC; out_vid_r <= '0;
    end else begin
      if (q_we) tail_r <= tail_r + 1'b1;
      unique case (state_r)
        S_CLR: begin
          cnt_r <= cnt_r + 1'b1;
          out_valid_r <= (cnt_r == '1) && clr_ack_r;
          if (cnt_r == '1) begin
            state_r <= S_IDLE;
            if (clr_ack_r) begin
              out_kind_r <= EV_ACC; out_vid_r <= '0;
              out_last_r <= 1'b1; out_empty_r <= 1'b1;
            end
          end
        end
        S_IDLE: begin
          out_valid_r <= start && (mode_t'(in_mode) == MODE_STEP) && (head_r == tail_r);
          if (start) begin
            src_r <= in_src_vertex;
            dst_r <= in_dst_vertex;
            unique case (mode_t'(in_mode))
              MODE_CLEAR: begin
                state_r <= S_CLR; clr_ack_r <= 1'b1; cnt_r <= '0;
                head_r <= '0; tail_r <= '0;
              end
              MODE_ADD:   state_r <= S_ADD;
              MODE_START: state_r <= S_START;
              MODE_STEP: begin
                if (head_r == tail_r) begin
                  out_kind_r <= EV_REJ; out_vid_r <= '0;
                  out_last_r <= 1'b1; out_empty_r <= 1'b1;
                end else begin
                  state_r <= S_QRD;
                end
              end
              default: ;
            endcase
          end
        end
        S_ADD: begin
          state_r <= S_IDLE;
          out_valid_r <= 1'b1; out_vid_r <= '0; out_last_r <= 1'b1;
          out_kind_r <= (deg_q < DEG_W'(MAX_DEGREE)) ? EV_ACC : EV_REJ;
          out_empty_r <= (head_r == tail_r);
        end
        S_START: begin
          state_r <= S_IDLE;
          out_valid_r <= 1'b1; out_last_r <= 1'b1;
          if (col_q == COL_WHITE) begin
            out_kind_r <= EV_DISC; out_vid_r <= src_r; out_empty_r <= 1'b0;
          end else begin
            out_kind_r <= EV_REJ; out_vid_r <= '0; out_empty_r <= (head_r == tail_r);
          end
        end
        S_QRD: begin
          out_valid_r <= 1'b0;
          u_r <= q_q;
          head_r <= head_r + 1'b1;
          state_r <= S_DEG;
        end
        S_DEG: begin
          out_valid_r <= 1'b0;
          deg_r <= deg_q;
          i_r <= '0;
          state_r <= (deg_q == '0) ? S_DONE : S_NRD;
        end
        S_NRD: begin
          out_valid_r <= 1'b0;
          state_r <= S_CRD;
        end
        S_CRD: begin
          out_valid_r <= 1'b0;
          w_r <= tbl_q;
          state_r <= S_CHK;
        end
        S_CHK: begin
          out_valid_r <= (col_q == COL_WHITE);
          if (col_q == COL_WHITE) begin
            out_kind_r <= EV_DISC; out_vid_r <= w_r;
            out_last_r <= 1'b0; out_empty_r <= 1'b0;
          end
          i_r <= i_r + 1'b1;
          state_r <= (i_r + 1'b1 == deg_r) ? S_DONE : S_NRD;
        end
        S_DONE: begin
          state_r <= S_IDLE;
          out_valid_r <= 1'b1; out_kind_r <= EV_PROC; out_vid_r <= u_r;
          out_last_r <= 1'b1; out_empty_r <= (head_r == tail_r);
        end
        default: begin
          out_valid_r <= 1'b0;
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_event_kind  = out_kind_r;
  assign out_vertex_id   = out_vid_r;
  assign out_last_of_run = out_last_r;
  assign out_queue_empty = out_empty_r;

  a_disc_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_DISC |-> !out_queue_empty)
    else $error("discovered vertex but queue reported empty");
  a_ack_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == EV_ACC || out_event_kind == EV_REJ)
    |-> out_last_of_run && out_vertex_id == '0)
    else $error("accept or reject result malformed");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_run |-> !busy)
    else $error("final result while still busy");
endmodule
`default_nettype wire

@@ test/tb_breadth_first_traversal_top.sv @@
// testbench for the breadth-first traversal engine: queued commands, predicted events
`default_nettype none
module tb_breadth_first_traversal_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bft_pkg::*;

  typedef struct packed {
    mode_t mode;
    vert_t src;
    vert_t dst;
  } cmd_t;

  typedef struct packed {
    event_t kind;
    vert_t  vid;
    logic   last;
    logic   qempty;
  } evt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_mode = '0;
  vert_t in_src_vertex = '0;
  vert_t in_dst_vertex = '0;
  logic out_valid;
  logic [1:0] out_event_kind;
  vert_t out_vertex_id;
  logic out_last_of_run;
  logic out_queue_empty;

  breadth_first_traversal_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_src_vertex(in_src_vertex), .in_dst_vertex(in_dst_vertex),
    .out_valid(out_valid), .out_event_kind(out_event_kind), .out_vertex_id(out_vertex_id),
    .out_last_of_run(out_last_of_run), .out_queue_empty(out_queue_empty)
  );

  always #5 clk = ~clk;

  cmd_t pending_cmds[$];
  evt_t expected_events[$];
  int   gap_pct = 0;
  bit   hold_for_drain = 1'b0;
  int   mismatches = 0;
  bit   errors = 1'b0;
  int   sent_cnt = 0;
  int   accepted_cnt = 0;

  vert_t   adj_list[MAX_VERTICES][MAX_DEGREE];
  int      out_degree[MAX_VERTICES];
  colour_t colour[MAX_VERTICES];
  vert_t   bfs_fifo[$];

  function automatic void push_event(event_t k, vert_t v, logic last);
    evt_t e;
    e.kind = k;
    e.vid = v;
    e.last = last;
    e.qempty = (bfs_fifo.size() == 0);
    expected_events.insert(expected_events.size(), e);
  endfunction

  function automatic void predict_traversal(cmd_t c);
    vert_t u;
    vert_t w;
    case (c.mode)
      MODE_CLEAR: begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
          out_degree[i] = 0;
          colour[i] = COL_WHITE;
        end
        bfs_fifo.delete();
        push_event(EV_ACC, '0, 1'b1);
      end
      MODE_ADD: begin
        if (out_degree[c.src] >= MAX_DEGREE) begin
          push_event(EV_REJ, '0, 1'b1);
        end else begin
          adj_list[c.src][out_degree[c.src]] = c.dst;
          out_degree[c.src]++;
          push_event(EV_ACC, '0, 1'b1);
        end
      end
      MODE_START: begin
        if (colour[c.src] != COL_WHITE) begin
          push_event(EV_REJ, '0, 1'b1);
        end else begin
          colour[c.src] = COL_GRAY;
          bfs_fifo.insert(bfs_fifo.size(), c.src);
          push_event(EV_DISC, c.src, 1'b1);
        end
      end
      default: begin
        if (bfs_fifo.size() == 0) begin
          push_event(EV_REJ, '0, 1'b1);
        end else begin
          u = bfs_fifo.pop_front();
          for (int i = 0; i < out_degree[u]; i++) begin
            w = adj_list[u][i];
            if (colour[w] == COL_WHITE) begin
              colour[w] = COL_GRAY;
              bfs_fifo.insert(bfs_fifo.size(), w);
              push_event(EV_DISC, w, 1'b0);
            end
          end
          colour[u] = COL_BLACK;
          push_event(EV_PROC, u, 1'b1);
        end
      end
    endcase
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!(start && accepted_cnt < sent_cnt)) begin
        if (pending_cmds.size() > 0 && !hold_for_drain &&
            $urandom_range(99, 0) >= gap_pct) begin
          start <= 1'b1;
          in_mode <= pending_cmds[0].mode;
          in_src_vertex <= pending_cmds[0].src;
          in_dst_vertex <= pending_cmds[0].dst;
          sent_cnt++;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    evt_t got;
    evt_t exp_e;
    if (rst_n) begin
      if (start && !busy) begin
        predict_traversal(pending_cmds.pop_front());
        accepted_cnt++;
      end
      if (out_valid) begin
        got = {event_t'(out_event_kind), out_vertex_id, out_last_of_run, out_queue_empty};
        if (expected_events.size() == 0) begin
          errors = 1'b1;
          if (mismatches < 10)
            $display("unexpected transaction: %p", got);
          mismatches++;
        end else begin
          exp_e = expected_events.pop_front();
          if (got !== exp_e) begin
            errors = 1'b1;
            if (mismatches < 10)
              $display("mismatch: expected %p actual %p", exp_e, got);
            mismatches++;
          end
        end
      end
    end
  end

  function automatic cmd_t make_cmd(mode_t m, int s, int d);
    cmd_t c;
    c.mode = m;
    c.src = vert_t'(s);
    c.dst = vert_t'(d);
    return c;
  endfunction

  function automatic void queue_cmd(mode_t m, int s, int d);
    pending_cmds.insert(pending_cmds.size(), make_cmd(m, s, d));
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || expected_events.size() > 0 || start)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // small random graph on a few vertices, then a start and a run of steps with occasional random commands mixed in
  task automatic queue_traversal(int nverts);
    int base;
    int nedges;
    base = $urandom_range(255, 0);
    nedges = $urandom_range(12, 3);
    queue_cmd(MODE_CLEAR, $urandom, $urandom);
    for (int i = 0; i < nedges; i++)
      queue_cmd(MODE_ADD, (base + $urandom_range(nverts - 1, 0)) % 256,
                (base + $urandom_range(nverts - 1, 0)) % 256);
    queue_cmd(MODE_START, base, $urandom);
    for (int i = 0; i < nverts + 1; i++) begin
      if ($urandom_range(9, 0) == 0)
        queue_cmd(mode_t'($urandom_range(3, 0)), $urandom, $urandom);
      else
        queue_cmd(MODE_STEP, $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    gap_pct = 31;
    // directed: extremes, full list, duplicate and self loops, rejections
    queue_cmd(MODE_STEP, 8'hff, 8'hff);
    queue_cmd(MODE_ADD, 0, 255);
    queue_cmd(MODE_ADD, 0, 255);
    queue_cmd(MODE_ADD, 0, 0);
    queue_cmd(MODE_ADD, 255, 0);
    for (int i = 0; i < 30; i++)
      queue_cmd(MODE_ADD, 1, i + 2);
    queue_cmd(MODE_ADD, 1, 100);
    queue_cmd(MODE_ADD, 1, 101);
    queue_cmd(MODE_ADD, 1, 102);
    queue_cmd(MODE_START, 0, 8'haa);
    queue_cmd(MODE_START, 0, 0);
    queue_cmd(MODE_START, 1, 0);
    queue_cmd(MODE_STEP, 0, 0);
    queue_cmd(MODE_STEP, 0, 0);
    queue_cmd(MODE_STEP, 0, 0);
    queue_cmd(MODE_STEP, 0, 0);
    queue_cmd(MODE_START, 255, 0);
    wait_drained();
    hold_for_drain = 1'b0;
    gap_pct = 55;
    for (int i = 0; i < 2; i++)
      queue_traversal($urandom_range(8, 2));
    wait_drained();
    gap_pct = 0;
    for (int i = 0; i < 2; i++)
      queue_traversal($urandom_range(8, 2));
    wait_drained();
    if (!errors) begin
      $display("breadth_first_traversal_top test passed");
    end else begin
      $display("breadth_first_traversal_top test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("breadth_first_traversal_top test failed");
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
rtl/core/bft_pkg.sv
rtl/core/breadth_first_traversal_top.sv
test/tb_breadth_first_traversal_top.sv
